### hdl/bia_pkg.sv
// ============================================================================
// bia_pkg
// Shared types and constants for the bitmap ID allocator.
// ============================================================================
package bia_pkg;

    // Field widths
    localparam int ID_W     = 10;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;

    // IDs the 10-bit ID field can name
    localparam int MAX_IDS = 2 ** ID_W;

    // Default pool size
    localparam int NUM_IDS_DEF = 1024;

    // Map word geometry
    localparam int WORD_W = 32;
    localparam int BIT_W  = $clog2(WORD_W);

    // Reset value of the limit register
    localparam logic [ID_W-1:0] HIGHEST_ID_RST = 10'd1023;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESERVE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FREE_UNUSED  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RESERVE_USED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ABOVE_LIMIT  = 3'd4;

    // Request transaction
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   id;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic [ID_W-1:0]     result_id;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

endpackage

### hdl/bitmap_id_allocator.sv
// ============================================================================
// bitmap_id_allocator
// Lowest-free-ID allocator over a used-bit map kept in a word memory.
// ============================================================================
// The used bits live in a synchronous memory of 32-bit words with one "full"
// flag per word in flip-flops. A transaction that touches the map steps
// through accept, word select and memory read, then modify and write back;
// one that resolves without it (pool exhausted, ID above the limit, unused
// opcode) ends at word select with no read. The registered memory read keeps
// modify a step of its own. A new request is taken once the previous one has
// finished, even while its response still waits in the output register. Each
// word carries a valid flag cleared at reset, so the map reads as all free
// right after reset with no clearing pass. Only IDs up to the smaller of
// NUM_IDS - 1 and 1023 are stored, since no ID above that can be named.
module bitmap_id_allocator #(
    parameter int NUM_IDS = bia_pkg::NUM_IDS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bia_pkg::ID_W-1:0]  cfg_data,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  bia_pkg::req_t             in_data,

    output logic                      out_valid,
    input  logic                      out_ready,
    output bia_pkg::rsp_t             out_data
);

    localparam int ID_W    = bia_pkg::ID_W;
    localparam int WORD_W  = bia_pkg::WORD_W;
    localparam int BIT_W   = bia_pkg::BIT_W;
    localparam int MAP_IDS = (NUM_IDS < bia_pkg::MAX_IDS) ? NUM_IDS : bia_pkg::MAX_IDS;
    localparam int WORDS   = (MAP_IDS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [ID_W-1:0] MAP_LAST = ID_W'(MAP_IDS - 1);

    // ------------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------------
    bia_pkg::state_t                   state_reg, state_next;
    logic [ID_W-1:0]                   highest_id_reg;
    logic [bia_pkg::FUNC_W-1:0]        func_reg;
    logic [ID_W-1:0]                   id_reg;
    logic [WORDS-1:0]                  full_reg;
    logic [WORDS-1:0]                  wvalid_reg;
    logic [WADDR_W-1:0]                addr_reg;
    logic                              rd_valid_reg;
    logic [WORD_W-1:0]                 rd_data_reg;
    logic [WORD_W-1:0]                 mem [WORDS];
    logic                              out_valid_reg;
    bia_pkg::rsp_t                     out_data_reg;

    logic [ID_W-1:0]                   lim;
    logic [WADDR_W-1:0]                lim_word;
    logic [BIT_W-1:0]                  lim_lo;
    logic [WADDR_W-1:0]                id_word;
    logic [BIT_W-1:0]                  id_bit;
    logic                              cand_any;
    logic [WADDR_W-1:0]                cand_idx;
    logic                              early;
    bia_pkg::rsp_t                     early_rsp;
    logic [WADDR_W-1:0]                rd_addr;

    logic [WORD_W-1:0]                 cur_word;
    logic [WORD_W-1:0]                 probe;
    logic                              zero_found;
    logic [BIT_W-1:0]                  zero_bit;
    logic [WORD_W-1:0]                 new_word;
    logic                              upd_write;
    bia_pkg::rsp_t                     upd_rsp;

    logic                              accept;
    logic                              rd_en;
    logic                              done;
    logic                              fire;
    logic                              wr_en;
    bia_pkg::rsp_t                     rsp;

    // ------------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            highest_id_reg <= bia_pkg::HIGHEST_ID_RST;
        else if (cfg_valid)
            highest_id_reg <= cfg_data;
    end

    // Limit saturated to the stored map
    assign lim      = (highest_id_reg > MAP_LAST) ? MAP_LAST : highest_id_reg;
    assign lim_word = WADDR_W'(lim >> BIT_W);
    assign lim_lo   = lim[BIT_W-1:0];
    assign id_word  = WADDR_W'(id_reg >> BIT_W);
    assign id_bit   = id_reg[BIT_W-1:0];

    // ------------------------------------------------------------------------
    // Lookup: first word at or below the limit word that is not full
    // ------------------------------------------------------------------------
    always_comb
    begin
        cand_any = 1'b0;
        cand_idx = '0;
        for (int w = WORDS - 1; w >= 0; w--)
        begin
            if (!full_reg[w] && (w <= int'(lim_word)))
            begin
                cand_any = 1'b1;
                cand_idx = WADDR_W'(w);
            end
        end
    end

    // Lookup decision: resolve now or read a word
    always_comb
    begin
        early     = 1'b0;
        early_rsp = '{result_id: id_reg, status: bia_pkg::STATUS_OK};
        rd_addr   = id_word;
        case (func_reg)
            bia_pkg::FUNC_ALLOC:
            begin
                rd_addr = cand_idx;
                if (!cand_any)
                begin
                    early     = 1'b1;
                    early_rsp = '{result_id: '0, status: bia_pkg::STATUS_EXHAUSTED};
                end
            end
            bia_pkg::FUNC_FREE, bia_pkg::FUNC_RESERVE:
            begin
                if (id_reg > lim)
                begin
                    early     = 1'b1;
                    early_rsp = '{result_id: id_reg, status: bia_pkg::STATUS_ABOVE_LIMIT};
                end
            end
            default:
            begin
                early = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Update: modify the word read from memory
    // ------------------------------------------------------------------------
    assign cur_word = rd_valid_reg ? rd_data_reg : '0;

    // Bits above the limit count as used in the limit word
    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
            probe[b] = cur_word[b] || ((addr_reg == lim_word) && (b > int'(lim_lo)));
    end

    // Lowest clear bit
    always_comb
    begin
        zero_found = 1'b0;
        zero_bit   = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (!probe[b])
            begin
                zero_found = 1'b1;
                zero_bit   = BIT_W'(b);
            end
        end
    end

    always_comb
    begin
        new_word  = cur_word;
        upd_write = 1'b0;
        upd_rsp   = '{result_id: id_reg, status: bia_pkg::STATUS_OK};
        case (func_reg)
            bia_pkg::FUNC_ALLOC:
            begin
                if (zero_found)
                begin
                    new_word[zero_bit] = 1'b1;
                    upd_write          = 1'b1;
                    upd_rsp.result_id  = (ID_W'(addr_reg) << BIT_W) | ID_W'(zero_bit);
                end
                else
                begin
                    upd_rsp = '{result_id: '0, status: bia_pkg::STATUS_EXHAUSTED};
                end
            end
            bia_pkg::FUNC_FREE:
            begin
                if (cur_word[id_bit])
                begin
                    new_word[id_bit] = 1'b0;
                    upd_write        = 1'b1;
                end
                else
                begin
                    upd_rsp.status = bia_pkg::STATUS_FREE_UNUSED;
                end
            end
            default:
            begin
                if (!cur_word[id_bit])
                begin
                    new_word[id_bit] = 1'b1;
                    upd_write        = 1'b1;
                end
                else
                begin
                    upd_rsp.status = bia_pkg::STATUS_RESERVE_USED;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    assign fire = done && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bia_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = bia_pkg::ST_LOOKUP;
            end
            bia_pkg::ST_LOOKUP:
            begin
                if (!early)
                    state_next = bia_pkg::ST_UPDATE;
                else if (fire)
                    state_next = bia_pkg::ST_IDLE;
            end
            bia_pkg::ST_UPDATE:
            begin
                if (fire)
                    state_next = bia_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bia_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        done     = 1'b0;
        rsp      = upd_rsp;
        case (state_reg)
            bia_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            bia_pkg::ST_LOOKUP:
            begin
                rd_en = !early;
                done  = early;
                rsp   = early_rsp;
            end
            bia_pkg::ST_UPDATE:
            begin
                done = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;
    assign wr_en  = fire && (state_reg == bia_pkg::ST_UPDATE) && upd_write;

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bia_pkg::ST_IDLE;
            full_reg      <= '0;
            wvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                full_reg[addr_reg]   <= &new_word;
                wvalid_reg[addr_reg] <= 1'b1;
            end
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= in_data.func;
            id_reg   <= in_data.id;
        end
        if (rd_en)
        begin
            addr_reg     <= rd_addr;
            rd_valid_reg <= wvalid_reg[rd_addr];
        end
        if (fire)
            out_data_reg <= rsp;
    end

    // ------------------------------------------------------------------------
    // Word memory
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
        if (wr_en)
            mem[addr_reg] <= new_word;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // A word can only be full after it has been written
    a_full_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg & ~wvalid_reg) == '0)
        else $error("full flag set on a word never written");

    // A successful allocation stays within the limit
    a_alloc_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (func_reg == bia_pkg::FUNC_ALLOC) && (rsp.status == bia_pkg::STATUS_OK))
        |-> (rsp.result_id <= lim))
        else $error("allocated ID above limit");

    // Exhaustion reports ID zero
    a_exhaust_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (rsp.status == bia_pkg::STATUS_EXHAUSTED)) |-> (rsp.result_id == '0))
        else $error("exhausted response with nonzero ID");

    // An accepted request always moves to lookup
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == bia_pkg::ST_LOOKUP))
        else $error("accepted request did not start lookup");

endmodule

### tb/tb.sv
// ============================================================================
// tb
// Self-checking bench for the bitmap ID allocator. A short scripted sequence
// covers allocation order, misuse errors, pool exhaustion, lowered limits and
// the spare opcode. Random phases then run under several limit settings with
// random idling on both sides and one long output stall. Every response is
// compared against an in-bench model of the used-ID map, or against the scripted response where the sequence pins one.
// ============================================================================
module tb;

    localparam int ID_W     = bia_pkg::ID_W;
    localparam int FUNC_W   = bia_pkg::FUNC_W;
    localparam int STATUS_W = bia_pkg::STATUS_W;

    // Opcode with no defined operation
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    localparam int POOL_IDS     = bia_pkg::NUM_IDS_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 192;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 10;

    // One row of the scripted sequence: a request, or a limit write
    typedef struct {
        bit                  is_cfg;
        logic [FUNC_W-1:0]   func;
        logic [ID_W-1:0]     id;
        bit                  pinned;
        logic [ID_W-1:0]     rid;
        logic [STATUS_W-1:0] st;
    } script_row_t;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [ID_W-1:0] cfg_data  = '0;
    logic            in_valid  = 1'b0;
    logic            in_ready;
    bia_pkg::req_t   in_data   = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    bia_pkg::rsp_t   out_data;

    // Model state: used bits and the current limit register
    bit              id_in_use [POOL_IDS];
    logic [ID_W-1:0] id_limit = bia_pkg::HIGHEST_ID_RST;

    // Responses still owed by the block, oldest first
    bia_pkg::rsp_t pending_rsp [$];

    // Scripted response for the request on the bus, when one is given
    bit            pin_on  = 1'b0;
    bia_pkg::rsp_t pin_rsp = '0;

    int  mismatches   = 0;
    int  cycle_count  = 0;
    int  tx_gap       = 0;
    int  hold_cycles  = 0;
    bit  tx_idle_mode = 1'b1;
    bit  rx_idle_mode = 1'b1;

    script_row_t script [25] = '{
        '{0, bia_pkg::FUNC_ALLOC,   10'd0,    1, 10'd0,    bia_pkg::STATUS_OK},
        '{0, bia_pkg::FUNC_ALLOC,   10'd0,    1, 10'd1,    bia_pkg::STATUS_OK},
        '{0, bia_pkg::FUNC_FREE,    10'd0,    1, 10'd0,    bia_pkg::STATUS_OK},
        '{0, bia_pkg::FUNC_FREE,    10'd0,    1, 10'd0,    bia_pkg::STATUS_FREE_UNUSED},
        '{0, bia_pkg::FUNC_RESERVE, 10'd1023, 1, 10'd1023, bia_pkg::STATUS_OK},
        '{0, bia_pkg::FUNC_RESERVE, 10'd1023, 1, 10'd1023, bia_pkg::STATUS_RESERVE_USED},
        '{0, FUNC_SPARE,            10'd1023, 1, 10'd1023, bia_pkg::STATUS_OK},
        '{0, FUNC_SPARE,            10'd0,    1, 10'd0,    bia_pkg::STATUS_OK},
        '{0, bia_pkg::FUNC_ALLOC,   10'h2AA,  1, 10'd0,    bia_pkg::STATUS_OK},
        '{1, bia_pkg::FUNC_ALLOC,   10'd2,    0, 10'd0,    bia_pkg::STATUS_OK},
        '{0, bia_pkg::FUNC_FREE,    10'd1023, 1, 10'd1023, bia_pkg::STATUS_ABOVE_LIMIT},
        '{0, bia_pkg::FUNC_RESERVE, 10'd3,    1, 10'd3,    bia_pkg::STATUS_ABOVE_LIMIT},
        '{0, bia_pkg::FUNC_ALLOC,   10'd0,    0, 10'd0,    bia_pkg::STATUS_OK},
        '{0, bia_pkg::FUNC_ALLOC,   10'd0,    1, 10'd0,    bia_pkg::STATUS_EXHAUSTED},
        '{0, bia_pkg::FUNC_FREE,    10'd1,    0, 10'd0,    bia_pkg::STATUS_OK},
        '{0, bia_pkg::FUNC_ALLOC,   10'h155,  0, 10'd0,    bia_pkg::STATUS_OK},
        '{1, bia_pkg::FUNC_ALLOC,   10'd0,    0, 10'd0,    bia_pkg::STATUS_OK},
        '{0, bia_pkg::FUNC_ALLOC,   10'd0,    1, 10'd0,    bia_pkg::STATUS_EXHAUSTED},
        '{0, bia_pkg::FUNC_FREE,    10'd0,    0, 10'd0,    bia_pkg::STATUS_OK},
        '{0, bia_pkg::FUNC_ALLOC,   10'd0,    0, 10'd0,    bia_pkg::STATUS_OK},
        '{0, bia_pkg::FUNC_RESERVE, 10'd1,    1, 10'd1,    bia_pkg::STATUS_ABOVE_LIMIT},
        '{1, bia_pkg::FUNC_ALLOC,   10'd1023, 0, 10'd0,    bia_pkg::STATUS_OK},
        '{0, bia_pkg::FUNC_FREE,    10'd1023, 0, 10'd0,    bia_pkg::STATUS_OK},
        '{0, bia_pkg::FUNC_RESERVE, 10'd1,    1, 10'd1,    bia_pkg::STATUS_RESERVE_USED},
        '{0, bia_pkg::FUNC_ALLOC,   10'd0,    0, 10'd0,    bia_pkg::STATUS_OK}
    };

    bitmap_id_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Apply one request to the model map and return the response it owes
    function automatic bia_pkg::rsp_t allocator_response(bia_pkg::req_t r);
        bia_pkg::rsp_t rsp;
        int            lim;
        lim = (int'(id_limit) > POOL_IDS - 1) ? POOL_IDS - 1 : int'(id_limit);
        rsp.result_id = r.id;
        rsp.status    = bia_pkg::STATUS_OK;
        if (r.func == bia_pkg::FUNC_ALLOC)
        begin
            rsp.result_id = '0;
            rsp.status    = bia_pkg::STATUS_EXHAUSTED;
            for (int i = 0; i <= lim; i++)
            begin
                if (!id_in_use[i])
                begin
                    id_in_use[i]  = 1'b1;
                    rsp.result_id = ID_W'(i);
                    rsp.status    = bia_pkg::STATUS_OK;
                    break;
                end
            end
        end
        else if (r.func == bia_pkg::FUNC_FREE || r.func == bia_pkg::FUNC_RESERVE)
        begin
            if (int'(r.id) > lim)
                rsp.status = bia_pkg::STATUS_ABOVE_LIMIT;
            else if (r.func == bia_pkg::FUNC_FREE)
            begin
                if (!id_in_use[r.id])
                    rsp.status = bia_pkg::STATUS_FREE_UNUSED;
                else
                    id_in_use[r.id] = 1'b0;
            end
            else
            begin
                if (id_in_use[r.id])
                    rsp.status = bia_pkg::STATUS_RESERVE_USED;
                else
                    id_in_use[r.id] = 1'b1;
            end
        end
        return rsp;
    endfunction

    task automatic flag_mismatch(string msg);
        mismatches++;
        $display("[%0d] MISMATCH: %s", cycle_count, msg);
    endtask

    // Wait time for one transaction; zero throughout a burst stretch
    function automatic int draw_gap(bit idle_mode);
        return idle_mode ? $urandom_range(0, 11) : 0;
    endfunction

    // Bus monitor: predicts at request acceptance, checks at response acceptance
    always @(posedge clk)
    begin
        bia_pkg::rsp_t want;
        bia_pkg::rsp_t got;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("tb failed");
                $finish;
            end
            else
            begin
                if (cfg_valid && cfg_ready)
                    id_limit = cfg_data;
                if (in_valid && in_ready)
                begin
                    want = allocator_response(in_data);
                    if (pin_on)
                        want = pin_rsp;
                    pending_rsp.push_back(want);
                end
                if (out_valid && out_ready)
                begin
                    got = out_data;
                    if (pending_rsp.size() == 0)
                        flag_mismatch($sformatf("unexpected response id %0d status %0d",
                                                got.result_id, got.status));
                    else
                    begin
                        want = pending_rsp.pop_front();
                        if (got.result_id !== want.result_id)
                            flag_mismatch($sformatf("result_id %0d, expected %0d",
                                                    got.result_id, want.result_id));
                        if (got.status !== want.status)
                            flag_mismatch($sformatf("status %0d, expected %0d (id %0d)",
                                                    got.status, want.status,
                                                    want.result_id));
                    end
                end
            end
        end
    end

    // Response side: random ready gaps, plus one long hold when requested
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                gap         = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    rx_idle_mode = ~rx_idle_mode;
                gap = draw_gap(rx_idle_mode);
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Offer one request and hold it until taken; called at a falling edge
    task automatic send_request(bia_pkg::req_t r, bit pinned, bia_pkg::rsp_t pinned_rsp);
        if (tx_gap > 0)
            repeat (tx_gap) @(negedge clk);
        pin_on   = pinned;
        pin_rsp  = pinned_rsp;
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if ($urandom_range(0, 39) == 0)
            tx_idle_mode = ~tx_idle_mode;
        tx_gap = draw_gap(tx_idle_mode);
        if (tx_gap > 0)
            in_valid <= 1'b0;
    endtask

    // Drop valid if still up, then wait for every owed response
    task automatic drain_requests();
        if (tx_gap == 0)
        begin
            in_valid <= 1'b0;
            tx_gap   = 1;
        end
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Limit register write, done only with the block idle
    task automatic write_limit(logic [ID_W-1:0] value);
        drain_requests();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        int            phase_limit [8];
        int            lim;
        int            win;
        int            k;
        bia_pkg::req_t r;
        bia_pkg::rsp_t exp_rsp;

        phase_limit = '{31, 1023, 0, 32, 63, 1, 33, 0};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Scripted sequence
        foreach (script[i])
        begin
            if (script[i].is_cfg)
                write_limit(script[i].id);
            else
            begin
                r.func            = script[i].func;
                r.id              = script[i].id;
                exp_rsp.result_id = script[i].rid;
                exp_rsp.status    = script[i].st;
                send_request(r, script[i].pinned, exp_rsp);
            end
        end

        // Random phases, one limit setting each
        exp_rsp = '0;
        for (int p = 0; p < 8; p++)
        begin
            lim = (p == 7) ? $urandom_range(2, 1022) : phase_limit[p];
            write_limit(ID_W'(lim));
            // IDs drawn near the low end so frees and reserves hit used bits
            win = (lim < 64) ? lim + 1 : 63;
            if (p == 1)
                hold_cycles = LONG_HOLD;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                k = $urandom_range(0, 99);
                if (k < 45)
                    r.func = bia_pkg::FUNC_ALLOC;
                else if (k < 75)
                    r.func = bia_pkg::FUNC_FREE;
                else if (k < 95)
                    r.func = bia_pkg::FUNC_RESERVE;
                else
                    r.func = FUNC_SPARE;
                if ($urandom_range(0, 9) == 0)
                    r.id = ID_W'($urandom);
                else
                    r.id = ID_W'($urandom_range(0, win));
                send_request(r, 1'b0, exp_rsp);
            end
        end

        // Wind down and give stray responses time to show
        drain_requests();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
